>>> rtl/core/mpd_pkg.sv
package mpd_pkg;

  localparam int unsigned COEF_W      = 64;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned MAX_LEN_DEF = 64;
  localparam logic [COEF_W-1:0] MOD_RESET = 64'd2;

  // command codes on the request channel
  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_RUN    = 2'd2;

  typedef enum logic {
    OP_DIV,
    OP_MUL
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [COEF_W-1:0] coeff;
  } in_item_t;

  typedef struct packed {
    logic [COEF_W-1:0] quotient_coeff;
    logic [IDX_W-1:0]  coeff_index;
    logic              divides;
    logic              empty_res;
    logic              overflow;
    logic              last;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RA_RD, ST_RA_GO, ST_RA_WT,
    ST_RB_RD, ST_RB_GO, ST_RB_WT,
    ST_INV_RD, ST_INV_LD,
    ST_EU_CHK, ST_EU_DIV, ST_EU_MS, ST_EU_MUL,
    ST_DV_RD, ST_DV_GO, ST_DV_WT,
    ST_DJ_RD, ST_DJ_GO, ST_DJ_WT,
    ST_CK_RD, ST_CK_GO, ST_CK_WT,
    ST_CA_RD, ST_CA_GO, ST_CA_WT,
    ST_TS_RD, ST_TS_CHK,
    ST_EM_RD, ST_EM_OUT,
    ST_EMPTY
  } seq_state_t;

  function automatic logic [COEF_W-1:0] add_m(input logic [COEF_W-1:0] a,
                                              input logic [COEF_W-1:0] b,
                                              input logic [COEF_W-1:0] n);
    logic [COEF_W-1:0] gap;
    gap = n - b;
    return (a >= gap) ? (a - gap) : (a + b);
  endfunction

  function automatic logic [COEF_W-1:0] sub_m(input logic [COEF_W-1:0] a,
                                              input logic [COEF_W-1:0] b,
                                              input logic [COEF_W-1:0] n);
    return (a >= b) ? (a - b) : (a + (n - b));
  endfunction

endpackage

>>> rtl/core/modular_poly_exact_divide.sv
// Exact polynomial division modulo n. Dividend and divisor coefficients are
// loaded lowest degree first with cmd 0 and cmd 1, one request per cycle,
// up to MAX_LEN each; further loads are dropped and flagged as overflow. A
// cmd 2 request runs long division modulo the configured modulus using the
// inverse of the divisor's top coefficient, verifies the low coefficients of
// Q*B against A, and emits the quotient (trailing zeros removed), one result
// per coefficient, or a single empty result. Both stores and the overflow
// flag are cleared after every run. The run is worked by one shared
// bit-serial unit that does every modular multiply, division and
// reduction in turn; no request is accepted while a run or its results
// are under way.
module modular_poly_exact_divide #(
  parameter int unsigned MAX_LEN = mpd_pkg::MAX_LEN_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  mpd_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output mpd_pkg::out_item_t        out_data,
  input  logic                      cfg_wr_en,
  input  logic [mpd_pkg::COEF_W-1:0] cfg_wr_data
);
  import mpd_pkg::*;

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned CW = $clog2(MAX_LEN + 1);

  seq_state_t state_r, state_nxt;

  // control registers
  logic [COEF_W-1:0] modulus_r;
  logic [CW-1:0]     la_r, la_nxt;
  logic [CW-1:0]     lb_r, lb_nxt;
  logic              ov_r, ov_nxt;
  logic [CW-1:0]     i_r, i_nxt;
  logic [CW-1:0]     j_r, j_nxt;
  logic [CW-1:0]     top_r, top_nxt;
  logic              divf_r, divf_nxt;
  logic              out_valid_r, out_valid_nxt;

  // datapath registers
  logic [COEF_W-1:0] inv_r, inv_nxt;
  logic [COEF_W-1:0] q_r, q_nxt;
  logic [COEF_W-1:0] c_r, c_nxt;
  logic [COEF_W-1:0] r0_r, r0_nxt;
  logic [COEF_W-1:0] r1_r, r1_nxt;
  logic [COEF_W-1:0] t0_r, t0_nxt;
  logic [COEF_W-1:0] t1_r, t1_nxt;
  logic [COEF_W-1:0] qe_r, qe_nxt;
  out_item_t         out_r, out_nxt;

  logic [COEF_W-1:0] n_eff;
  logic              in_acc;
  logic              out_free;
  logic [CW-1:0]     lq;
  logic [CW-1:0]     p_idx;
  logic [CW-1:0]     qw_idx;

  // arithmetic unit
  arith_req_t        ar_req;
  logic [COEF_W-1:0] ar_a, ar_b;
  logic              ar_done;
  logic [COEF_W-1:0] ar_res, ar_quo;

  // memory ports
  logic              a_we, b_we, r_we, q_we;
  logic [AW-1:0]     a_wa, b_wa, r_wa, q_wa;
  logic [COEF_W-1:0] a_wd, b_wd, r_wd, q_wd;
  logic              a_re, b_re, r_re, q_re;
  logic [AW-1:0]     a_ra, b_ra, r_ra, q_ra;
  logic [COEF_W-1:0] a_rd, b_rd, r_rd, q_rd;

  assign n_eff    = (modulus_r < 64'd2) ? 64'd2 : modulus_r;
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign lq       = la_r - lb_r + CW'(1);
  assign qw_idx   = i_r - lb_r + CW'(1);
  assign p_idx    = qw_idx + j_r;

  mpd_ram #(.DEPTH(MAX_LEN), .AW(AW)) u_a_ram (
    .clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd),
    .re(a_re), .raddr(a_ra), .rdata(a_rd)
  );

  mpd_ram #(.DEPTH(MAX_LEN), .AW(AW)) u_b_ram (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd),
    .re(b_re), .raddr(b_ra), .rdata(b_rd)
  );

  // working remainder
  mpd_ram #(.DEPTH(MAX_LEN), .AW(AW)) u_r_ram (
    .clk(clk), .we(r_we), .waddr(r_wa), .wdata(r_wd),
    .re(r_re), .raddr(r_ra), .rdata(r_rd)
  );

  mpd_ram #(.DEPTH(MAX_LEN), .AW(AW)) u_q_ram (
    .clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd),
    .re(q_re), .raddr(q_ra), .rdata(q_rd)
  );

  mpd_arith u_arith (
    .clk(clk), .rst_n(rst_n), .req(ar_req),
    .a_in(ar_a), .b_in(ar_b), .n_in(n_eff),
    .done(ar_done), .res(ar_res), .quo(ar_quo)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_data.cmd == CMD_RUN) begin
          if (lb_r == '0 || la_r < lb_r) begin
            state_nxt = ST_EMPTY;
          end else begin
            state_nxt = ST_RA_RD;
          end
        end
      end
      ST_RA_RD:  state_nxt = ST_RA_GO;
      ST_RA_GO:  state_nxt = ST_RA_WT;
      ST_RA_WT: begin
        if (ar_done) begin
          state_nxt = (i_r + CW'(1) == la_r) ? ST_RB_RD : ST_RA_RD;
        end
      end
      ST_RB_RD:  state_nxt = ST_RB_GO;
      ST_RB_GO:  state_nxt = ST_RB_WT;
      ST_RB_WT: begin
        if (ar_done) begin
          state_nxt = (i_r + CW'(1) == lb_r) ? ST_INV_RD : ST_RB_RD;
        end
      end
      ST_INV_RD: state_nxt = ST_INV_LD;
      ST_INV_LD: state_nxt = ST_EU_CHK;
      ST_EU_CHK: begin
        if (r1_r == '0) begin
          state_nxt = (r0_r == 64'd1) ? ST_DV_RD : ST_EMPTY;
        end else begin
          state_nxt = ST_EU_DIV;
        end
      end
      ST_EU_DIV: begin
        if (ar_done) begin
          state_nxt = ST_EU_MS;
        end
      end
      ST_EU_MS:  state_nxt = ST_EU_MUL;
      ST_EU_MUL: begin
        if (ar_done) begin
          state_nxt = ST_EU_CHK;
        end
      end
      ST_DV_RD:  state_nxt = ST_DV_GO;
      ST_DV_GO:  state_nxt = ST_DV_WT;
      ST_DV_WT: begin
        if (ar_done) begin
          state_nxt = ST_DJ_RD;
        end
      end
      ST_DJ_RD:  state_nxt = ST_DJ_GO;
      ST_DJ_GO:  state_nxt = ST_DJ_WT;
      ST_DJ_WT: begin
        if (ar_done) begin
          if (j_r + CW'(1) != lb_r) begin
            state_nxt = ST_DJ_RD;
          end else if (i_r + CW'(1) != lb_r) begin
            state_nxt = ST_DV_RD;
          end else if (lb_r >= CW'(2)) begin
            state_nxt = ST_CK_RD;
          end else begin
            state_nxt = ST_TS_RD;
          end
        end
      end
      ST_CK_RD:  state_nxt = ST_CK_GO;
      ST_CK_GO:  state_nxt = ST_CK_WT;
      ST_CK_WT: begin
        if (ar_done) begin
          if (j_r + CW'(1) <= i_r && j_r + CW'(1) < lq) begin
            state_nxt = ST_CK_RD;
          end else begin
            state_nxt = ST_CA_RD;
          end
        end
      end
      ST_CA_RD:  state_nxt = ST_CA_GO;
      ST_CA_GO:  state_nxt = ST_CA_WT;
      ST_CA_WT: begin
        if (ar_done) begin
          if (ar_res != c_r) begin
            state_nxt = ST_EMPTY;
          end else if (i_r + CW'(2) < lb_r) begin
            state_nxt = ST_CK_RD;
          end else begin
            state_nxt = ST_TS_RD;
          end
        end
      end
      ST_TS_RD:  state_nxt = ST_TS_CHK;
      ST_TS_CHK: begin
        if (q_rd != '0) begin
          state_nxt = ST_EM_RD;
        end else if (top_r == CW'(1)) begin
          state_nxt = ST_EMPTY;
        end else begin
          state_nxt = ST_TS_RD;
        end
      end
      ST_EM_RD:  state_nxt = ST_EM_OUT;
      ST_EM_OUT: begin
        if (out_free) begin
          state_nxt = (i_r + CW'(1) == top_r) ? ST_IDLE : ST_EM_RD;
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath, memory and unit control
  always_comb begin
    la_nxt        = la_r;
    lb_nxt        = lb_r;
    ov_nxt        = ov_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    top_nxt       = top_r;
    divf_nxt      = divf_r;
    inv_nxt       = inv_r;
    q_nxt         = q_r;
    c_nxt         = c_r;
    r0_nxt        = r0_r;
    r1_nxt        = r1_r;
    t0_nxt        = t0_r;
    t1_nxt        = t1_r;
    qe_nxt        = qe_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    ar_req = '{start: 1'b0, op: OP_DIV};
    ar_a   = a_rd;
    ar_b   = n_eff;

    a_we = 1'b0;  a_wa = la_r[AW-1:0];  a_wd = in_data.coeff;
    b_we = 1'b0;  b_wa = lb_r[AW-1:0];  b_wd = in_data.coeff;
    r_we = 1'b0;  r_wa = i_r[AW-1:0];   r_wd = ar_res;
    q_we = 1'b0;  q_wa = qw_idx[AW-1:0]; q_wd = ar_res;
    a_re = 1'b0;  a_ra = i_r[AW-1:0];
    b_re = 1'b0;  b_ra = i_r[AW-1:0];
    r_re = 1'b0;  r_ra = i_r[AW-1:0];
    q_re = 1'b0;  q_ra = i_r[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data.cmd)
            CMD_LOAD_A: begin
              if (la_r < CW'(MAX_LEN)) begin
                a_we   = 1'b1;
                la_nxt = la_r + CW'(1);
              end else begin
                ov_nxt = 1'b1;
              end
            end
            CMD_LOAD_B: begin
              if (lb_r < CW'(MAX_LEN)) begin
                b_we   = 1'b1;
                lb_nxt = lb_r + CW'(1);
              end else begin
                ov_nxt = 1'b1;
              end
            end
            CMD_RUN: begin
              i_nxt    = '0;
              divf_nxt = (la_r == '0);
            end
            default: begin
              ov_nxt = ov_r;
            end
          endcase
        end
      end
      // reduce dividend into the working remainder
      ST_RA_RD: a_re = 1'b1;
      ST_RA_GO: begin
        ar_req = '{start: 1'b1, op: OP_DIV};
      end
      ST_RA_WT: begin
        if (ar_done) begin
          r_we  = 1'b1;
          i_nxt = (i_r + CW'(1) == la_r) ? '0 : i_r + CW'(1);
        end
      end
      // reduce divisor in place
      ST_RB_RD: b_re = 1'b1;
      ST_RB_GO: begin
        ar_req = '{start: 1'b1, op: OP_DIV};
        ar_a   = b_rd;
      end
      ST_RB_WT: begin
        if (ar_done) begin
          b_we  = 1'b1;
          b_wa  = i_r[AW-1:0];
          b_wd  = ar_res;
          i_nxt = i_r + CW'(1);
        end
      end
      // extended euclid on the top divisor coefficient
      ST_INV_RD: begin
        b_re = 1'b1;
        b_ra = AW'(lb_r - CW'(1));
      end
      ST_INV_LD: begin
        r0_nxt = n_eff;
        r1_nxt = b_rd;
        t0_nxt = '0;
        t1_nxt = 64'd1;
      end
      ST_EU_CHK: begin
        if (r1_r == '0) begin
          inv_nxt  = t0_r;
          i_nxt    = la_r - CW'(1);
          divf_nxt = 1'b0;
        end else begin
          ar_req = '{start: 1'b1, op: OP_DIV};
          ar_a   = r0_r;
          ar_b   = r1_r;
        end
      end
      ST_EU_DIV: begin
        if (ar_done) begin
          r0_nxt = r1_r;
          r1_nxt = ar_res;
          // quotient never exceeds n, so reduction is one compare
          qe_nxt = (ar_quo == n_eff) ? '0 : ar_quo;
        end
      end
      ST_EU_MS: begin
        ar_req = '{start: 1'b1, op: OP_MUL};
        ar_a   = qe_r;
        ar_b   = t1_r;
      end
      ST_EU_MUL: begin
        if (ar_done) begin
          t0_nxt = t1_r;
          t1_nxt = sub_m(t0_r, ar_res, n_eff);
        end
      end
      // long division, top coefficient down
      ST_DV_RD: r_re = 1'b1;
      ST_DV_GO: begin
        ar_req = '{start: 1'b1, op: OP_MUL};
        ar_a   = r_rd;
        ar_b   = inv_r;
      end
      ST_DV_WT: begin
        if (ar_done) begin
          q_nxt = ar_res;
          q_we  = 1'b1;
          j_nxt = '0;
        end
      end
      ST_DJ_RD: begin
        r_re = 1'b1;
        r_ra = p_idx[AW-1:0];
        b_re = 1'b1;
        b_ra = j_r[AW-1:0];
      end
      ST_DJ_GO: begin
        ar_req = '{start: 1'b1, op: OP_MUL};
        ar_a   = q_r;
        ar_b   = b_rd;
      end
      ST_DJ_WT: begin
        if (ar_done) begin
          r_we = 1'b1;
          r_wa = p_idx[AW-1:0];
          r_wd = sub_m(r_rd, ar_res, n_eff);
          if (j_r + CW'(1) != lb_r) begin
            j_nxt = j_r + CW'(1);
          end else if (i_r + CW'(1) != lb_r) begin
            i_nxt = i_r - CW'(1);
          end else begin
            i_nxt   = '0;
            j_nxt   = '0;
            c_nxt   = '0;
            top_nxt = lq;
          end
        end
      end
      // low coefficients of q*b against a
      ST_CK_RD: begin
        q_re = 1'b1;
        q_ra = j_r[AW-1:0];
        b_re = 1'b1;
        b_ra = AW'(i_r - j_r);
      end
      ST_CK_GO: begin
        ar_req = '{start: 1'b1, op: OP_MUL};
        ar_a   = q_rd;
        ar_b   = b_rd;
      end
      ST_CK_WT: begin
        if (ar_done) begin
          c_nxt = add_m(c_r, ar_res, n_eff);
          j_nxt = j_r + CW'(1);
        end
      end
      ST_CA_RD: a_re = 1'b1;
      ST_CA_GO: begin
        ar_req = '{start: 1'b1, op: OP_DIV};
      end
      ST_CA_WT: begin
        if (ar_done) begin
          i_nxt = i_r + CW'(1);
          j_nxt = '0;
          c_nxt = '0;
        end
      end
      // strip trailing zero coefficients
      ST_TS_RD: begin
        q_re = 1'b1;
        q_ra = AW'(top_r - CW'(1));
      end
      ST_TS_CHK: begin
        if (q_rd != '0) begin
          i_nxt = '0;
        end else begin
          top_nxt  = top_r - CW'(1);
          divf_nxt = 1'b1;
        end
      end
      ST_EM_RD: q_re = 1'b1;
      ST_EM_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{quotient_coeff: q_rd, coeff_index: IDX_W'(i_r), divides: 1'b1,
                      empty_res: 1'b0, overflow: ov_r,
                      last: (i_r + CW'(1) == top_r)};
          i_nxt = i_r + CW'(1);
          if (i_r + CW'(1) == top_r) begin
            la_nxt = '0;
            lb_nxt = '0;
            ov_nxt = 1'b0;
          end
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{quotient_coeff: '0, coeff_index: '0, divides: divf_r,
                      empty_res: 1'b1, overflow: ov_r, last: 1'b1};
          la_nxt = '0;
          lb_nxt = '0;
          ov_nxt = 1'b0;
        end
      end
      default: begin
        i_nxt = i_r;
      end
    endcase

    // a failed check or failed inverse gives the empty result with divides clear
    if (state_r == ST_CA_WT && ar_done && ar_res != c_r) begin
      divf_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      modulus_r   <= MOD_RESET;
      la_r        <= '0;
      lb_r        <= '0;
      ov_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      la_r        <= la_nxt;
      lb_r        <= lb_nxt;
      ov_r        <= ov_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        modulus_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    top_r  <= top_nxt;
    divf_r <= divf_nxt;
    inv_r  <= inv_nxt;
    q_r    <= q_nxt;
    c_r    <= c_nxt;
    r0_r   <= r0_nxt;
    r1_r   <= r1_nxt;
    t0_r   <= t0_nxt;
    t1_r   <= t1_nxt;
    qe_r   <= qe_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> rtl/core/mpd_ram.sv
module mpd_ram #(
  parameter int unsigned DEPTH = mpd_pkg::MAX_LEN_DEF,
  parameter int unsigned AW    = 6
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [mpd_pkg::COEF_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [mpd_pkg::COEF_W-1:0] rdata
);
  import mpd_pkg::*;

  logic [COEF_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read enable
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/mpd_arith.sv
module mpd_arith (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mpd_pkg::arith_req_t       req,
  input  logic [mpd_pkg::COEF_W-1:0] a_in,
  input  logic [mpd_pkg::COEF_W-1:0] b_in,
  input  logic [mpd_pkg::COEF_W-1:0] n_in,
  output logic                      done,
  output logic [mpd_pkg::COEF_W-1:0] res,
  output logic [mpd_pkg::COEF_W-1:0] quo
);
  import mpd_pkg::*;

  logic              busy_r;
  logic              done_r;
  arith_op_t         op_r;
  logic              phase_r;
  logic [5:0]        cnt_r;
  logic [COEF_W-1:0] acc_r;
  logic [COEF_W-1:0] sh_r;
  logic [COEF_W-1:0] a_r;
  logic [COEF_W-1:0] b_r;
  logic [COEF_W-1:0] n_r;
  logic [COEF_W:0]   trial;
  logic              ge;

  // restoring division step
  assign trial = {acc_r, sh_r[COEF_W-1]};
  assign ge    = (trial >= {1'b0, b_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 6'd63 && (op_r == OP_DIV || phase_r)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r    <= req.op;
      acc_r   <= '0;
      sh_r    <= (req.op == OP_MUL) ? b_in : a_in;
      a_r     <= a_in;
      b_r     <= b_in;
      n_r     <= n_in;
      cnt_r   <= '0;
      phase_r <= 1'b0;
    end else if (busy_r) begin
      case (op_r)
        OP_DIV: begin
          acc_r <= ge ? COEF_W'(trial - {1'b0, b_r}) : trial[COEF_W-1:0];
          sh_r  <= {sh_r[COEF_W-2:0], ge};
          cnt_r <= cnt_r + 6'd1;
        end
        OP_MUL: begin
          // doubling and conditional add take alternate cycles
          if (!phase_r) begin
            acc_r   <= add_m(acc_r, acc_r, n_r);
            phase_r <= 1'b1;
          end else begin
            if (sh_r[COEF_W-1]) begin
              acc_r <= add_m(acc_r, a_r, n_r);
            end
            sh_r    <= {sh_r[COEF_W-2:0], 1'b0};
            phase_r <= 1'b0;
            cnt_r   <= cnt_r + 6'd1;
          end
        end
        default: begin
          acc_r <= acc_r;
        end
      endcase
    end
  end

  assign done = done_r;
  assign res  = acc_r;
  assign quo  = sh_r;

endmodule

>>> sim/modular_poly_exact_divide_tb.sv
module modular_poly_exact_divide_tb;
  import mpd_pkg::*;

  // the one command code the package leaves unnamed: ignored by the block
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int STORE_DEPTH = 64;
  localparam int QUIET_LIMIT = 600000;   // cycles with no handshake at all
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic [1:0]  cmd;
    logic [63:0] coeff;
    bit          typed;
    out_item_t   want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_wr_en;
  logic [63:0] cfg_wr_data;

  modular_poly_exact_divide uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #1 clk = ~clk;

  // shadow of the block's state, updated as each request is accepted
  logic [63:0] modulus_shadow;
  logic [63:0] dividend_copy [STORE_DEPTH];
  logic [63:0] divisor_copy [STORE_DEPTH];
  logic [63:0] quotient_copy [STORE_DEPTH];
  int          dividend_len;
  int          divisor_len;
  bit          dropped_load;

  out_item_t   pending_quotients [$];   // results still owed by the block
  out_item_t   fresh_results [$];       // results of the latest request
  int          errors;
  int          requests_sent;
  int          send_idle_pct;
  int          stall_pct;
  int          quiet_cycles;

  // ---------------------------------------------------------------- arithmetic
  function automatic logic [63:0] mod_add(logic [63:0] a, logic [63:0] b, logic [63:0] n);
    logic [63:0] gap;
    gap = n - b;
    return (a >= gap) ? (a - gap) : (a + b);
  endfunction

  function automatic logic [63:0] mod_sub(logic [63:0] a, logic [63:0] b, logic [63:0] n);
    return (a >= b) ? (a - b) : (a + (n - b));
  endfunction

  function automatic logic [63:0] mod_mul(logic [63:0] a, logic [63:0] b, logic [63:0] n);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return 64'(prod % {64'd0, n});
  endfunction

  // extended euclid on reduced a; fails when gcd(a, n) is not one
  function automatic bit mod_inverse(logic [63:0] a, logic [63:0] n, output logic [63:0] inv);
    logic [63:0] r0, r1, t0, t1, q, tmp;
    r0 = n;
    r1 = a;
    t0 = 0;
    t1 = 1;
    inv = 0;
    while (r1 != 0) begin
      q = r0 / r1;
      tmp = r0 - q * r1;
      r0 = r1;
      r1 = tmp;
      tmp = mod_sub(t0, mod_mul(q % n, t1, n), n);
      t0 = t1;
      t1 = tmp;
    end
    if (r0 != 1) return 0;
    inv = t0;
    return 1;
  endfunction

  function automatic logic [63:0] active_modulus();
    return (modulus_shadow < 2) ? 64'd2 : modulus_shadow;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // ----------------------------------------------------------------- predictor
  // a single empty result closes the run
  function automatic out_item_t empty_quotient(bit divides, bit ovf);
    out_item_t r;
    r = '0;
    r.divides = divides;
    r.empty_res = 1'b1;
    r.overflow = ovf;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic predict_request(in_item_t it);
    logic [63:0] n, inv, q, c;
    logic [63:0] rem [STORE_DEPTH];
    logic [63:0] bred [STORE_DEPTH];
    out_item_t r;
    int lq, top, p;
    bit ok;
    fresh_results.delete();
    case (it.cmd)
      CMD_LOAD_A: begin
        if (dividend_len < STORE_DEPTH) begin
          dividend_copy[dividend_len] = it.coeff;
          dividend_len++;
        end else dropped_load = 1;
      end
      CMD_LOAD_B: begin
        if (divisor_len < STORE_DEPTH) begin
          divisor_copy[divisor_len] = it.coeff;
          divisor_len++;
        end else dropped_load = 1;
      end
      CMD_RUN: begin
        n = active_modulus();
        if (divisor_len == 0 || dividend_len < divisor_len) begin
          fresh_results.push_back(empty_quotient(dividend_len == 0, dropped_load));
        end else begin
          for (int i = 0; i < dividend_len; i++) rem[i] = dividend_copy[i] % n;
          for (int i = 0; i < divisor_len; i++) bred[i] = divisor_copy[i] % n;
          lq = dividend_len - divisor_len + 1;
          ok = mod_inverse(bred[divisor_len-1], n, inv);
          if (ok) begin
            // schoolbook long division from the top coefficient down
            for (int i = dividend_len - 1; i >= divisor_len - 1; i--) begin
              q = mod_mul(rem[i], inv, n);
              quotient_copy[i-divisor_len+1] = q;
              for (int j = 0; j < divisor_len; j++) begin
                p = i - divisor_len + 1 + j;
                rem[p] = mod_sub(rem[p], mod_mul(q, bred[j], n), n);
              end
            end
            // low coefficients of q*b must reproduce a
            for (int i = 0; i + 1 < divisor_len && ok; i++) begin
              c = 0;
              for (int j = 0; j <= i && j < lq; j++)
                c = mod_add(c, mod_mul(quotient_copy[j], bred[i-j], n), n);
              if (c != dividend_copy[i] % n) ok = 0;
            end
          end
          if (!ok) begin
            fresh_results.push_back(empty_quotient(1'b0, dropped_load));
          end else begin
            top = lq;
            while (top > 0 && quotient_copy[top-1] == 0) top--;
            if (top == 0) begin
              fresh_results.push_back(empty_quotient(1'b1, dropped_load));
            end else begin
              for (int i = 0; i < top; i++) begin
                r.quotient_coeff = quotient_copy[i];
                r.coeff_index = IDX_W'(i);
                r.divides = 1'b1;
                r.empty_res = 1'b0;
                r.overflow = dropped_load;
                r.last = (i + 1 == top);
                fresh_results.push_back(r);
              end
            end
          end
        end
        dividend_len = 0;
        divisor_len = 0;
        dropped_load = 0;
      end
      default: ;  // unused code, ignored
    endcase
  endtask

  // -------------------------------------------------------------------- driver
  // called right after a rising edge; holds the request until it is taken
  task automatic push_req(in_item_t it, bit typed = 0, out_item_t want = '0);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    predict_request(it);
    // typed rows keep the hand-written expectation, the predictor only tracks state
    if (typed) pending_quotients.push_back(want);
    else foreach (fresh_results[k]) pending_quotients.push_back(fresh_results[k]);
    requests_sent++;
  endtask

  task automatic push_cmd(logic [1:0] cmd, logic [63:0] coeff);
    in_item_t it;
    it.cmd = cmd;
    it.coeff = coeff;
    push_req(it);
  endtask

  // builds a = q*b so the division is exact, then maybe pads, breaks or
  // lifts coefficients above the modulus; loads are interleaved at random
  task automatic send_division(int lb, int lq);
    logic [63:0] b [STORE_DEPTH];
    logic [63:0] q [STORE_DEPTH];
    logic [63:0] a [STORE_DEPTH];
    logic [63:0] n;
    int la, ai, bi, k;
    n = active_modulus();
    for (int i = 0; i < lb; i++) b[i] = rand64() % n;
    if (b[lb-1] == 0) b[lb-1] = 1;
    for (int i = 0; i < lq; i++) q[i] = rand64() % n;
    la = lq + lb - 1;
    for (int i = 0; i < STORE_DEPTH; i++) a[i] = 0;
    for (int i = 0; i < lq; i++)
      for (int j = 0; j < lb; j++)
        a[i+j] = mod_add(a[i+j], mod_mul(q[i], b[j], n), n);
    // zero padding on top gives trailing zeros in the quotient
    if (la < STORE_DEPTH && $urandom_range(3) == 0) begin
      k = $urandom_range(1, 3);
      if (la + k > STORE_DEPTH) k = STORE_DEPTH - la;
      la += k;
    end
    if ($urandom_range(4) == 0) begin
      k = $urandom_range(la - 1);
      a[k] = mod_add(a[k], 1, n);
    end
    for (int i = 0; i < la; i++)
      if ($urandom_range(3) == 0 && a[i] <= ~n) a[i] = a[i] + n;
    for (int i = 0; i < lb; i++)
      if ($urandom_range(3) == 0 && b[i] <= ~n) b[i] = b[i] + n;
    ai = 0;
    bi = 0;
    while (ai < la || bi < lb) begin
      if (bi >= lb || (ai < la && $urandom_range(1) == 0)) begin
        push_cmd(CMD_LOAD_A, a[ai]);
        ai++;
      end else begin
        push_cmd(CMD_LOAD_B, b[bi]);
        bi++;
      end
    end
    push_cmd(CMD_RUN, 64'd0);
  endtask

  // wait until every owed result is back and the block has gone quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_quotients.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_modulus(logic [63:0] m);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    modulus_shadow = m;
  endtask

  task automatic random_phase(logic [63:0] m, int idle, int stall, int target);
    int stop_at, burst;
    settle();
    write_modulus(m);
    send_idle_pct = idle;
    stall_pct = stall;
    stop_at = requests_sent + target;
    while (requests_sent < stop_at) begin
      if ($urandom_range(9) < 7) begin
        send_division($urandom_range(1, 4), $urandom_range(1, 5));
      end else begin
        burst = $urandom_range(1, 4);
        repeat (burst) push_cmd(2'($urandom_range(3)), rand64());
      end
    end
  endtask

  // ----------------------------------------------------------- result checker
  always @(negedge clk) begin
    if (rst_n) out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_quotients.size() == 0) begin
        $display("%0t: unexpected result, got coeff %h idx %0d div %b empty %b ovf %b last %b",
                 $time, out_data.quotient_coeff, out_data.coeff_index, out_data.divides,
                 out_data.empty_res, out_data.overflow, out_data.last);
        errors++;
      end else begin
        want = pending_quotients.pop_front();
        if (out_data.quotient_coeff !== want.quotient_coeff ||
            out_data.coeff_index !== want.coeff_index ||
            out_data.divides !== want.divides ||
            out_data.empty_res !== want.empty_res ||
            out_data.overflow !== want.overflow ||
            out_data.last !== want.last) begin
          $display("%0t: mismatch expected coeff %h idx %0d div %b empty %b ovf %b last %b",
                   $time, want.quotient_coeff, want.coeff_index, want.divides,
                   want.empty_res, want.overflow, want.last);
          $display("%0t:          actual   coeff %h idx %0d div %b empty %b ovf %b last %b",
                   $time, out_data.quotient_coeff, out_data.coeff_index, out_data.divides,
                   out_data.empty_res, out_data.overflow, out_data.last);
          errors++;
        end
      end
    end
  end

  // watchdog: any handshake resets the quiet count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------ directed table
  // modulus is still at its reset value of two here
  localparam out_item_t EMPTY_DIV = '{64'd0, 6'd0, 1'b1, 1'b1, 1'b0, 1'b1};
  localparam out_item_t EMPTY_NODIV = '{64'd0, 6'd0, 1'b0, 1'b1, 1'b0, 1'b1};

  dir_row_t dir_tab [29] = '{
    '{CMD_RUN,    64'd0, 1, EMPTY_DIV},     // run right after reset, nothing loaded
    '{CMD_LOAD_B, 64'd5, 0, '0},
    '{CMD_RUN,    64'd0, 1, EMPTY_DIV},     // empty dividend shorter than divisor
    '{CMD_LOAD_A, 64'd3, 0, '0},
    '{CMD_RUN,    64'd0, 1, EMPTY_NODIV},   // empty divisor
    '{CMD_UNUSED, '1,    0, '0},            // unused code is dropped
    '{CMD_RUN,    64'd0, 1, EMPTY_DIV},
    '{CMD_LOAD_A, 64'd1, 0, '0},            // 1 + x^2 over (1 + x) mod 2
    '{CMD_LOAD_A, 64'd0, 0, '0},
    '{CMD_LOAD_A, 64'd1, 0, '0},
    '{CMD_LOAD_B, 64'd1, 0, '0},
    '{CMD_LOAD_B, 64'd1, 0, '0},
    '{CMD_RUN,    64'd0, 0, '0},
    '{CMD_LOAD_A, 64'd1, 0, '0},            // top divisor coefficient zero
    '{CMD_LOAD_A, 64'd1, 0, '0},
    '{CMD_LOAD_B, 64'd1, 0, '0},
    '{CMD_LOAD_B, 64'd0, 0, '0},
    '{CMD_RUN,    64'd0, 1, EMPTY_NODIV},
    '{CMD_LOAD_A, '1,    0, '0},            // coefficients above the modulus
    '{CMD_LOAD_B, 64'd3, 0, '0},
    '{CMD_RUN,    64'd0, 0, '0},
    '{CMD_LOAD_A, 64'd0, 0, '0},            // zero quotient that divides
    '{CMD_LOAD_B, 64'd1, 0, '0},
    '{CMD_RUN,    64'd0, 1, EMPTY_DIV},
    '{CMD_LOAD_A, 64'd1, 0, '0},            // check of low coefficients fails
    '{CMD_LOAD_A, 64'd1, 0, '0},
    '{CMD_LOAD_B, 64'd0, 0, '0},
    '{CMD_LOAD_B, 64'd1, 0, '0},
    '{CMD_RUN,    64'd0, 1, EMPTY_NODIV}
  };

  // ------------------------------------------------------------------ sequence
  initial begin
    in_item_t it;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    errors = 0;
    requests_sent = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    quiet_cycles = 0;
    modulus_shadow = MOD_RESET;
    dividend_len = 0;
    divisor_len = 0;
    dropped_load = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[r]) begin
      it.cmd = dir_tab[r].cmd;
      it.coeff = dir_tab[r].coeff;
      push_req(it, dir_tab[r].typed, dir_tab[r].want);
    end

    // large prime, no idling; both stores overflow and the largest sizes live here
    settle();
    write_modulus(64'hFFFF_FFFF_FFFF_FFC5);
    repeat (STORE_DEPTH + 1) push_cmd(CMD_LOAD_A, rand64());
    repeat (STORE_DEPTH + 1) push_cmd(CMD_LOAD_B, rand64());
    push_cmd(CMD_RUN, 64'd0);
    send_division(1, STORE_DEPTH);
    random_phase(64'hFFFF_FFFF_FFFF_FFC5, 0, 0, 30);
    random_phase(64'd3, 73, 0, 20);
    random_phase(64'd65537, 0, 73, 20);
    random_phase(64'd0, 18, 18, 15);
    random_phase(64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 15);   // not prime: many fail
    random_phase(64'd1000003, 18, 18, 20);
    random_phase(64'd1, 73, 73, 15);

    settle();
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_quotients.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
